>>> rtl/core/hlsc_pkg.sv
// Shared types and constants for the length-prefix to start-code converter.
`default_nettype none
package hlsc_pkg;

   // Width of the section size field by default
   localparam int DefaultSizeBits = 24;

   // Record header layout and framing constants
   localparam int          MinRecordSize = 7;
   localparam int          HdrCountPos   = 5;
   localparam logic [7:0]  SpsCountMask  = 8'h1F;
   localparam logic [7:0]  RecordVersion = 8'h01;
   localparam int          PktLenBytes   = 4;
   localparam int          StartCodeLen  = 4;
   localparam logic [7:0]  StartCodeTail = 8'h01;

   // Output beat kinds
   localparam logic KindData = 1'b0;
   localparam logic KindEnd  = 1'b1;

   // Command queue between front and back
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   // Parser phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_HDR      = 4'd1,
      PH_SPS_HI   = 4'd2,
      PH_SPS_LO   = 4'd3,
      PH_SPS_DATA = 4'd4,
      PH_PPS_CNT  = 4'd5,
      PH_PPS_HI   = 4'd6,
      PH_PPS_LO   = 4'd7,
      PH_PPS_DATA = 4'd8,
      PH_PKT_LEN  = 4'd9,
      PH_PKT_DATA = 4'd10
   } phase_type;

   // One classified input byte: what the back end has to send for it
   typedef struct packed {
      logic       start_code;
      logic       has_data;
      logic       end_mark;
      logic [7:0] data;
   } cmd_type;

   // Front to queue write
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } qwrite_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

>>> rtl/core/hlsc_if.sv
// Valid/ready channel interfaces for the request and response streams.
`default_nettype none
interface hlsc_req_if import hlsc_pkg::*; #(
   parameter int SizeBits = DefaultSizeBits
);
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [7:0]          data_byte;
   logic [SizeBits-1:0] section_size;
   logic                key_frame;
   logic                section_last;

   modport source (
      output valid, req_type, data_byte, section_size, key_frame, section_last,
      input  ready
   );
   modport sink (
      input  valid, req_type, data_byte, section_size, key_frame, section_last,
      output ready
   );
endinterface

interface hlsc_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] out_byte;

   modport source (
      output valid, out_kind, out_byte,
      input  ready
   );
   modport sink (
      input  valid, out_kind, out_byte,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/core/hlsc_front.sv
// Front end: parses record and packet bytes and classifies each into a command.
`default_nettype none
module hlsc_front import hlsc_pkg::*; #(
   parameter int SizeBits = DefaultSizeBits
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                req_type,
   input  wire logic [7:0]          data_byte,
   input  wire logic [SizeBits-1:0] section_size,
   input  wire logic                key_frame,
   input  wire logic                section_last,
   output qwrite_type               qwrite
);

   localparam int CmpW = ((SizeBits > 32) ? SizeBits : 32) + 2;

   phase_type           phase_ff, phase_in;
   logic [SizeBits-1:0] pos_ff, pos_in;
   logic [23:0]         accum_ff, accum_in;
   logic [SizeBits-1:0] left_ff, left_in;
   logic [7:0]          entries_ff, entries_in;
   logic                stopped_ff, stopped_in;

   logic                restart, in_pkt;
   phase_type           ph_cur;
   logic [SizeBits-1:0] pos_cur, left_cur, left_dec;
   logic [23:0]         accum_cur;
   logic [31:0]         accum_sh, len_val;
   logic [7:0]          entries_cur, ent_dec;
   logic                stopped_cur;
   logic                act, at_end_pos, short4, overrun;
   logic [15:0]         len16;
   logic [CmpW-1:0]     len_sum;
   cmd_type             cmd;

   // Restart the section on idle or on a change of byte type
   assign in_pkt      = (phase_ff == PH_PKT_LEN) || (phase_ff == PH_PKT_DATA);
   assign restart     = (phase_ff == PH_IDLE) || (req_type != in_pkt);
   assign ph_cur      = restart ? (req_type ? PH_PKT_LEN : PH_HDR) : phase_ff;
   assign pos_cur     = restart ? '0 : pos_ff;
   assign accum_cur   = restart ? '0 : accum_ff;
   assign left_cur    = restart ? '0 : left_ff;
   assign entries_cur = restart ? '0 : entries_ff;
   assign stopped_cur = restart ? 1'b0 : stopped_ff;

   // Shared bound checks
   assign act        = !stopped_cur && (pos_cur < section_size);
   assign at_end_pos = ({1'b0, pos_cur} + {{SizeBits{1'b0}}, 1'b1}) == {1'b0, section_size};
   assign short4     = ({2'b00, pos_cur} + (SizeBits+2)'(PktLenBytes))
                       > {2'b00, section_size};
   assign accum_sh   = {accum_cur, data_byte};
   assign len16      = {accum_cur[7:0], data_byte};
   assign len_val    = (ph_cur == PH_PKT_LEN) ? accum_sh : {16'h0000, len16};
   assign len_sum    = CmpW'(pos_cur) + CmpW'(len_val) + CmpW'(1);
   assign overrun    = len_sum > CmpW'(section_size);
   assign ent_dec    = entries_cur - 8'd1;
   assign left_dec   = left_cur - {{(SizeBits-1){1'b0}}, 1'b1};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = ph_cur;
         if (act) begin
            unique case (ph_cur)
               PH_HDR: begin
                  if (pos_cur == SizeBits'(HdrCountPos))
                     phase_in = ((data_byte & SpsCountMask) != 8'd0) ? PH_SPS_HI : PH_PPS_CNT;
               end
               PH_SPS_HI: begin
                  if (!at_end_pos) phase_in = PH_SPS_LO;
               end
               PH_PPS_HI: begin
                  if (!at_end_pos) phase_in = PH_PPS_LO;
               end
               PH_SPS_LO: begin
                  if (overrun)            phase_in = PH_PPS_CNT;
                  else if (len16 != '0)   phase_in = PH_SPS_DATA;
                  else                    phase_in = (ent_dec != '0) ? PH_SPS_HI : PH_PPS_CNT;
               end
               PH_PPS_LO: begin
                  if (!overrun) begin
                     if (len16 != '0)        phase_in = PH_PPS_DATA;
                     else if (ent_dec != '0) phase_in = PH_PPS_HI;
                  end
               end
               PH_SPS_DATA: begin
                  if (left_dec == '0) phase_in = (ent_dec != '0) ? PH_SPS_HI : PH_PPS_CNT;
               end
               PH_PPS_DATA: begin
                  if (left_dec == '0 && ent_dec != '0) phase_in = PH_PPS_HI;
               end
               PH_PPS_CNT: begin
                  if (data_byte != '0) phase_in = PH_PPS_HI;
               end
               PH_PKT_LEN: begin
                  if (!(entries_cur == '0 && short4) && entries_cur == 8'(PktLenBytes - 1)
                      && !overrun && accum_sh != '0)
                     phase_in = PH_PKT_DATA;
               end
               PH_PKT_DATA: begin
                  if (left_dec == '0) phase_in = PH_PKT_LEN;
               end
               default: phase_in = ph_cur;
            endcase
         end
         if (section_last) phase_in = PH_IDLE;
      end
   end

   // Section counters, stop flag and command
   always_comb begin
      pos_in     = pos_ff;
      accum_in   = accum_ff;
      left_in    = left_ff;
      entries_in = entries_ff;
      stopped_in = stopped_ff;
      cmd        = '0;
      cmd.data   = data_byte;
      if (accept) begin
         pos_in     = (pos_cur == {SizeBits{1'b1}}) ? pos_cur
                      : pos_cur + {{(SizeBits-1){1'b0}}, 1'b1};
         accum_in   = accum_cur;
         left_in    = left_cur;
         entries_in = entries_cur;
         stopped_in = stopped_cur;
         if (act) begin
            unique case (ph_cur)
               PH_HDR: begin
                  if (pos_cur == '0) begin
                     if (!(key_frame && section_size >= SizeBits'(MinRecordSize)
                           && data_byte == RecordVersion))
                        stopped_in = 1'b1;
                  end else if (pos_cur == SizeBits'(HdrCountPos)) begin
                     entries_in = data_byte & SpsCountMask;
                  end
               end
               PH_SPS_HI, PH_PPS_HI: begin
                  if (at_end_pos) stopped_in = 1'b1;
                  else            accum_in   = {16'h0000, data_byte};
               end
               PH_SPS_LO, PH_PPS_LO: begin
                  accum_in = '0;
                  if (overrun) begin
                     if (ph_cur == PH_PPS_LO) stopped_in = 1'b1;
                  end else begin
                     cmd.start_code = 1'b1;
                     if (len16 != '0) begin
                        left_in = SizeBits'(len16);
                     end else begin
                        entries_in = ent_dec;
                        if (ph_cur == PH_PPS_LO && ent_dec == '0) stopped_in = 1'b1;
                     end
                  end
               end
               PH_SPS_DATA, PH_PPS_DATA: begin
                  cmd.has_data = 1'b1;
                  left_in      = left_dec;
                  if (left_dec == '0) begin
                     entries_in = ent_dec;
                     if (ph_cur == PH_PPS_DATA && ent_dec == '0) stopped_in = 1'b1;
                  end
               end
               PH_PPS_CNT: begin
                  entries_in = data_byte;
                  if (data_byte == '0) stopped_in = 1'b1;
               end
               PH_PKT_LEN: begin
                  if (entries_cur == '0 && short4) begin
                     stopped_in = 1'b1;
                  end else if (entries_cur == 8'(PktLenBytes - 1)) begin
                     entries_in = '0;
                     accum_in   = '0;
                     if (overrun) begin
                        stopped_in = 1'b1;
                     end else begin
                        cmd.start_code = 1'b1;
                        if (accum_sh != '0) left_in = SizeBits'(accum_sh);
                     end
                  end else begin
                     accum_in   = accum_sh[23:0];
                     entries_in = entries_cur + 8'd1;
                  end
               end
               PH_PKT_DATA: begin
                  cmd.has_data = 1'b1;
                  left_in      = left_dec;
               end
               default: stopped_in = 1'b1;
            endcase
         end
         // Close the section on its last byte
         if (section_last) begin
            cmd.end_mark = req_type;
            pos_in       = '0;
            accum_in     = '0;
            left_in      = '0;
            entries_in   = '0;
            stopped_in   = 1'b0;
         end
      end
   end

   assign qwrite = '{push: accept && (cmd.start_code || cmd.has_data || cmd.end_mark),
                     cmd: cmd};

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         stopped_ff <= 1'b0;
         entries_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         stopped_ff <= stopped_in;
         entries_ff <= entries_in;
      end
      pos_ff   <= pos_in;
      accum_ff <= accum_in;
      left_ff  <= left_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/hlsc_queue.sv
// Short command queue between the parser front end and the beat sequencer.
`default_nettype none
module hlsc_queue import hlsc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire qwrite_type qwrite,
   input  wire logic       pop,
   output cmd_type         head,
   output qstat_type       qstat
);

   cmd_type          mem [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = qwrite.push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (qwrite.push && !pop)      count_in = count_ff + QCntW'(1);
      else if (!qwrite.push && pop) count_in = count_ff - QCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store commands
   always_ff @(posedge clock) begin
      if (qwrite.push) mem[wr_ptr_ff] <= qwrite.cmd;
   end

   assign head  = mem[rd_ptr_ff];
   assign qstat = '{full: (count_ff == QCntW'(QueueDepth)), empty: (count_ff == '0)};

endmodule
`default_nettype wire

>>> rtl/core/hlsc_back.sv
// Back end: expands each command into start code, data and end marker beats.
`default_nettype none
module hlsc_back import hlsc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type head,
   input  wire logic    q_empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic         rsp_kind,
   output logic [7:0]   rsp_byte
);

   cmd_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [2:0] beat_ff, beat_in;
   logic [2:0] sc_beats, last_idx, rel;
   logic       in_sc, last_beat, done;

   // Locate the current beat within the command
   assign sc_beats  = cur_ff.start_code ? 3'(StartCodeLen) : 3'd0;
   assign last_idx  = sc_beats + {2'b00, cur_ff.has_data} + {2'b00, cur_ff.end_mark} - 3'd1;
   assign in_sc     = cur_ff.start_code && (beat_ff < 3'(StartCodeLen));
   assign rel       = beat_ff - sc_beats;
   assign last_beat = (beat_ff == last_idx);

   // Drive the beat
   always_comb begin
      rsp_kind = KindData;
      rsp_byte = 8'h00;
      if (in_sc) begin
         if (beat_ff == 3'(StartCodeLen - 1)) rsp_byte = StartCodeTail;
      end else if (cur_ff.has_data && rel == 3'd0) begin
         rsp_byte = cur_ff.data;
      end else begin
         rsp_kind = KindEnd;
      end
   end

   // Advance through beats, load the next command on the final one or when idle
   assign done      = busy_ff && rsp_ready && last_beat;
   assign pop       = (!busy_ff || done) && !q_empty;
   assign rsp_valid = busy_ff;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (pop) begin
         cur_in  = head;
         busy_in = 1'b1;
         beat_in = 3'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         beat_in = beat_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/h264_length_prefix_to_start_code.sv
// Top level: length-prefixed H.264 byte stream to start-code form.
//
//  channel   dir  beat contents                                          handshake
//  req_bus   in   req_type, data_byte, section_size, key_frame,
//                 section_last                                           valid/ready
//  rsp_bus   out  out_kind, out_byte                                     valid/ready
//
// One request beat per cycle; a beat that yields output leaves one command in a
// four-deep queue. The sequencer sends one response beat per cycle while rsp_ready
// is high: a payload byte is one beat, a start code four, an end marker one more. A
// beat's first response is offered once its command is queued and loaded by the
// sequencer, if free. Start-code bursts stall the request side only once the queue
// is full. Synchronous reset returns the parser to idle and empties the queue.
`default_nettype none
module h264_length_prefix_to_start_code import hlsc_pkg::*; #(
   parameter int SizeBits = DefaultSizeBits
) (
   input wire logic     clock,
   input wire logic     reset,
   hlsc_req_if.sink     req_bus,
   hlsc_rsp_if.source   rsp_bus
);

   qwrite_type q_write;
   qstat_type  q_stat;
   cmd_type    q_head;
   logic       q_pop;
   logic       req_accept;

   // Accept a beat while the queue has room
   assign req_bus.ready = !q_stat.full;
   assign req_accept    = req_bus.valid && req_bus.ready;

   hlsc_front #(.SizeBits(SizeBits)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req_type     (req_bus.req_type),
      .data_byte    (req_bus.data_byte),
      .section_size (req_bus.section_size),
      .key_frame    (req_bus.key_frame),
      .section_last (req_bus.section_last),
      .qwrite       (q_write)
   );

   hlsc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .qwrite (q_write),
      .pop    (q_pop),
      .head   (q_head),
      .qstat  (q_stat)
   );

   hlsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_stat.empty),
      .pop       (q_pop),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_kind  (rsp_bus.out_kind),
      .rsp_byte  (rsp_bus.out_byte)
   );

`ifndef NO_ASSERTIONS
   // Never write a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_write.push |-> !q_stat.full)
      else $error("command written into a full queue");

   // Never load from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("command read from an empty queue");

   // A closing packet beat leaves work behind for the sequencer
   a_end_kept: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.section_last && req_bus.req_type)
      |=> (!q_stat.empty || rsp_bus.valid))
      else $error("end of packet marker lost");
`endif

endmodule
`default_nettype wire
